// ===== design/ssv_pkg.sv =====
// shared types and constants for the strided slice view calculator
// no dependencies; used by every module of the block

package ssv_pkg;

   // field widths
   localparam int SIZE_W   = 31;
   localparam int INDEX_W  = 32;
   localparam int BASE_W   = 48;
   localparam int STRIDE_W = 62;
   localparam int OFFSET_W = 63;

   // serial units: numerator and multiplier operand are both one bit wider than a size
   localparam int NUM_W      = SIZE_W + 1;
   localparam int MUL_B_W    = SIZE_W + 1;
   localparam int STEP_COUNT = NUM_W;

   typedef struct packed {
      logic [SIZE_W-1:0]  dim_size;
      logic [SIZE_W-1:0]  old_stride;
      logic [INDEX_W-1:0] begin_index;
      logic [INDEX_W-1:0] end_index;
      logic [SIZE_W-1:0]  step_size;
      logic               sliced;
      logic [BASE_W-1:0]  base_offset;
      logic               last;
   } req_payload_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   new_size;
      logic [STRIDE_W-1:0] new_stride;
      logic [OFFSET_W-1:0] running_offset;
      logic                last_out;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRAP,
      ST_CLAMP_B,
      ST_CLAMP_E,
      ST_LEN,
      ST_START,
      ST_RUN,
      ST_ACC,
      ST_DONE
   } state_type;

   // controls from the sequencer to the serial units
   typedef struct packed {
      logic start;
      logic shift_en;
   } unit_ctrl_type;

endpackage

// ===== design/ssv_serial_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle while shift_en is set
// computes ceil(len / den) as (len + den - 1) / den; depends on ssv_pkg

module ssv_serial_div #(
   parameter int NUM_W = ssv_pkg::NUM_W,
   parameter int DEN_W = ssv_pkg::SIZE_W
) (
   input  logic                  clock,
   input  ssv_pkg::unit_ctrl_type ctrl,
   input  logic [DEN_W-1:0]      len,
   input  logic [DEN_W-1:0]      den,
   output logic [NUM_W-1:0]      quo
);
   import ssv_pkg::*;

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // one restoring step: shift in the next numerator bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, num_ff[NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = trial >= {1'b0, den_ff};
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (ctrl.start) begin
         num_in = NUM_W'({1'b0, len}) + NUM_W'({1'b0, den}) - NUM_W'(1);
         rem_in = '0;
         den_in = den;
      end else if (ctrl.shift_en) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // quotient has replaced the numerator once all steps are done
   assign quo = num_ff;

endmodule

// ===== design/ssv_serial_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle while shift_en is set
// narrow adder on the upper half of the product; depends on ssv_pkg

module ssv_serial_mul #(
   parameter int A_W = ssv_pkg::SIZE_W,
   parameter int B_W = ssv_pkg::MUL_B_W
) (
   input  logic                   clock,
   input  ssv_pkg::unit_ctrl_type ctrl,
   input  logic [A_W-1:0]         a,
   input  logic [B_W-1:0]         b,
   output logic [A_W+B_W-1:0]     prod
);
   import ssv_pkg::*;

   logic [A_W-1:0] a_ff, a_in;
   logic [A_W-1:0] hi_ff, hi_in;
   logic [B_W-1:0] lo_ff, lo_in;
   logic [A_W:0]   sum;

   // add the multiplicand when the low bit is set, then shift right
   always_comb begin
      sum   = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      a_in  = a_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (ctrl.start) begin
         a_in  = a;
         hi_in = '0;
         lo_in = b;
      end else if (ctrl.shift_en) begin
         hi_in = sum[A_W:1];
         lo_in = {sum[0], lo_ff[B_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign prod = {hi_ff, lo_ff};

endmodule

// ===== design/strided_slice_view_calc_core.sv =====
// after the input transfer come the index wrap, clamp and length states, a
// load, the 32 serial steps of the divider and multipliers, the offset add
// and the output load, which waits while an earlier result is stalled; one
// item at a time. a new item is taken while a result waits.
// reset: synchronous; clears the sequencer, output valid and the running
// offset, and the next item starts a new run
// top level; depends on ssv_pkg, ssv_serial_div, ssv_serial_mul

module strided_slice_view_calc_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ssv_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ssv_pkg::rsp_payload_type rsp_payload
);
   import ssv_pkg::*;

   localparam int SizeW     = SIZE_W;
   localparam int StepCount = STEP_COUNT;
   localparam int CntW      = $clog2(StepCount);
   localparam int IdxW      = SizeW + 2;

   state_type state_ff, state_in;

   logic [SizeW-1:0]       size_ff, size_in;
   logic [SizeW-1:0]       stride_ff, stride_in;
   logic [SizeW-1:0]       step_ff, step_in;
   logic signed [IdxW-1:0] b_ff, b_in;
   logic signed [IdxW-1:0] e_ff, e_in;
   logic [SizeW-1:0]       len_ff, len_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic                   last_ff, last_in;
   logic [OFFSET_W-1:0]    acc_ff, acc_in;
   logic                   at_start_ff, at_start_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   unit_ctrl_type          ctrl;
   logic                   in_xfer;
   logic                   out_free;
   logic                   rsp_load;
   logic                   run_done;
   logic [NUM_W-1:0]       quo;
   logic [SizeW+MUL_B_W-1:0] stride_prod;
   logic [SizeW+MUL_B_W-1:0] ofs_prod;
   logic signed [IdxW-1:0] size_s;
   logic [OFFSET_W-1:0]    acc_base;
   logic [OFFSET_W:0]      acc_sum;

   assign in_xfer  = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign run_done = cnt_ff == CntW'(StepCount - 1);
   assign size_s   = $signed({2'b00, size_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_WRAP;
         ST_WRAP:    state_in = ST_CLAMP_B;
         ST_CLAMP_B: state_in = ST_CLAMP_E;
         ST_CLAMP_E: state_in = ST_LEN;
         ST_LEN:     state_in = ST_START;
         ST_START:   state_in = ST_RUN;
         ST_RUN:     if (run_done) state_in = ST_ACC;
         ST_ACC:     state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready     = 1'b0;
      ctrl.start    = 1'b0;
      ctrl.shift_en = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_START: ctrl.start = 1'b1;
         ST_RUN:   ctrl.shift_en = 1'b1;
         ST_DONE:  rsp_load = out_free;
         default:  ;
      endcase
   end

   // index datapath: capture, wrap negatives, clamp, take the length
   always_comb begin
      size_in   = size_ff;
      stride_in = stride_ff;
      step_in   = step_ff;
      b_in      = b_ff;
      e_in      = e_ff;
      len_in    = len_ff;
      base_in   = base_ff;
      last_in   = last_ff;
      case (state_ff)
         ST_IDLE: begin
            size_in   = req_payload.dim_size;
            stride_in = req_payload.old_stride;
            base_in   = req_payload.base_offset;
            last_in   = req_payload.last;
            if (req_payload.sliced) begin
               b_in    = IdxW'($signed(req_payload.begin_index));
               e_in    = IdxW'($signed(req_payload.end_index));
               step_in = (req_payload.step_size == '0) ? SizeW'(1) : req_payload.step_size;
            end else begin
               b_in    = '0;
               e_in    = $signed({2'b00, req_payload.dim_size});
               step_in = SizeW'(1);
            end
         end
         ST_WRAP: begin
            if (b_ff < 0) b_in = b_ff + size_s;
            if (e_ff < 0) e_in = e_ff + size_s;
         end
         ST_CLAMP_B: begin
            if (b_ff < 0) b_in = '0;
            else if (b_ff >= size_s) b_in = size_s;
         end
         ST_CLAMP_E: begin
            if (e_ff < b_ff) e_in = b_ff;
            else if (e_ff >= size_s) e_in = size_s;
         end
         ST_LEN: begin
            // empty range contributes nothing to the offset
            if (b_ff == e_ff) begin
               b_in   = '0;
               len_in = '0;
            end else begin
               len_in = SizeW'(e_ff - b_ff);
            end
         end
         default: ;
      endcase
   end

   // step counter for the serial units
   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.start) cnt_in = '0;
      else if (ctrl.shift_en) cnt_in = cnt_ff + CntW'(1);
   end

   // running offset with saturation
   always_comb begin
      acc_base    = at_start_ff ? OFFSET_W'(base_ff) : acc_ff;
      acc_sum     = {1'b0, acc_base} + (OFFSET_W + 1)'(ofs_prod[STRIDE_W-1:0]);
      acc_in      = acc_ff;
      at_start_in = at_start_ff;
      if (state_ff == ST_ACC) begin
         acc_in      = acc_sum[OFFSET_W] ? '1 : acc_sum[OFFSET_W-1:0];
         at_start_in = last_ff;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.new_size       = quo[SizeW-1:0];
         rsp_data_in.new_stride     = stride_prod[STRIDE_W-1:0];
         rsp_data_in.running_offset = acc_ff;
         rsp_data_in.last_out       = last_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         at_start_ff  <= 1'b1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         at_start_ff  <= at_start_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      stride_ff   <= stride_in;
      step_ff     <= step_in;
      b_ff        <= b_in;
      e_ff        <= e_in;
      len_ff      <= len_in;
      base_ff     <= base_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ceiling of length over step
   ssv_serial_div #(
      .NUM_W (NUM_W),
      .DEN_W (SizeW)
   ) u_div (
      .clock (clock),
      .ctrl  (ctrl),
      .len   (len_ff),
      .den   (step_ff),
      .quo   (quo)
   );

   // new stride: old stride times step
   ssv_serial_mul #(
      .A_W (SizeW),
      .B_W (MUL_B_W)
   ) u_mul_stride (
      .clock (clock),
      .ctrl  (ctrl),
      .a     (stride_ff),
      .b     (MUL_B_W'(step_ff)),
      .prod  (stride_prod)
   );

   // offset contribution: begin times old stride
   ssv_serial_mul #(
      .A_W (SizeW),
      .B_W (MUL_B_W)
   ) u_mul_offset (
      .clock (clock),
      .ctrl  (ctrl),
      .a     (stride_ff),
      .b     (MUL_B_W'(b_ff[SizeW-1:0])),
      .prod  (ofs_prod)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== design/ssv_checker.sv =====
// port-level checks for the strided slice view calculator
// depends on ssv_pkg; bound to strided_slice_view_calc_core below

module ssv_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input ssv_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input ssv_pkg::rsp_payload_type rsp_payload
);
   import ssv_pkg::*;

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("result changed while stalled");

   // one item at a time: no transfer right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while busy");

   // a fresh result only comes from a busy block
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without work");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind strided_slice_view_calc_core ssv_checker u_ssv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
